>>> rtl/core/bdq_pkg.sv
// Shared types, codes and default sizes for the bounded double-ended queue.
package bdq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed widths of the request and result fields.
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

endpackage

>>> rtl/core/bdq_mem.sv
// Element store: one write port and one read port with registered read data.
module bdq_mem import bdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/bdq_ctrl.sv
// End pointers, occupancy, cached end values and result register of the deque.
module bdq_ctrl import bdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [MODE_W-1:0]     mode,
  input  logic [VALUE_W-1:0]    value,
  output logic                  busy,
  output logic                  done,
  output logic [STATUS_W-1:0]   status,
  output logic [VALUE_W-1:0]    popped,
  output logic [OCC_W-1:0]      occupancy,
  output logic [VALUE_W-1:0]    front_value,
  output logic [VALUE_W-1:0]    back_value,
  output logic                  wr_en,
  output logic [IW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [IW-1:0]         rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data
);

  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t state, state_next;

  // The back index is kept equal to front + count - 1 (modulo DEPTH), also when empty.
  logic [IW-1:0]         front_idx, back_idx;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH-1:0] front_val, back_val;
  logic [DATA_WIDTH-1:0] popped_val;
  logic [STATUS_W-1:0]   status_val;
  logic                  refill_front, refill_back;

  logic                  accept;
  logic                  is_push, is_full, is_empty;
  logic [IW-1:0]         front_inc, front_dec, back_inc, back_dec;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] front_fin, back_fin;
  logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
  logic [VALUE_W+DATA_WIDTH-1:0] popped_ext, front_ext, back_ext;
  logic [OCC_W+CW-1:0]   occ_ext;

  assign accept    = start && (state == S_IDLE);
  assign is_push   = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK);
  assign is_full   = (count == FULL_CNT);
  assign is_empty  = (count == '0);
  assign front_inc = (front_idx == LAST_IDX) ? '0 : front_idx + 1'b1;
  assign front_dec = (front_idx == '0) ? LAST_IDX : front_idx - 1'b1;
  assign back_inc  = (back_idx == LAST_IDX) ? '0 : back_idx + 1'b1;
  assign back_dec  = (back_idx == '0) ? LAST_IDX : back_idx - 1'b1;

  assign value_ext = {{DATA_WIDTH{1'b0}}, value};
  assign push_data = value_ext[DATA_WIDTH-1:0];

  // The memory write is done in the accept cycle; pops fetch the new end element.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = front_dec;
    wr_data = push_data;
    rd_en   = 1'b0;
    rd_addr = front_inc;
    if (accept) begin
      case (mode)
        MODE_PUSH_FRONT: begin
          wr_en   = !is_full;
          wr_addr = front_dec;
        end
        MODE_PUSH_BACK: begin
          wr_en   = !is_full;
          wr_addr = back_inc;
        end
        MODE_POP_FRONT: begin
          rd_en   = !is_empty;
          rd_addr = front_inc;
        end
        default: begin
          rd_en   = !is_empty;
          rd_addr = back_dec;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx    <= '0;
      back_idx     <= LAST_IDX;
      count        <= '0;
      refill_front <= 1'b0;
      refill_back  <= 1'b0;
    end else if (accept) begin
      refill_front <= 1'b0;
      refill_back  <= 1'b0;
      popped_val   <= '0;
      if (is_push && is_full) begin
        status_val <= STATUS_FULL;
      end else if (!is_push && is_empty) begin
        status_val <= STATUS_EMPTY;
      end else begin
        status_val <= STATUS_DONE;
        case (mode)
          MODE_PUSH_FRONT: begin
            front_idx <= front_dec;
            count     <= count + 1'b1;
            front_val <= push_data;
            if (is_empty) begin
              back_val <= push_data;
            end
          end
          MODE_PUSH_BACK: begin
            back_idx <= back_inc;
            count    <= count + 1'b1;
            back_val <= push_data;
            if (is_empty) begin
              front_val <= push_data;
            end
          end
          MODE_POP_FRONT: begin
            front_idx    <= front_inc;
            count        <= count - 1'b1;
            popped_val   <= front_val;
            refill_front <= 1'b1;
          end
          default: begin
            back_idx    <= back_dec;
            count       <= count - 1'b1;
            popped_val  <= back_val;
            refill_back <= 1'b1;
          end
        endcase
      end
    end else if (state == S_RESP) begin
      front_val <= front_fin;
      back_val  <= back_fin;
    end
  end

  assign front_fin = refill_front ? rd_data : front_val;
  assign back_fin  = refill_back ? rd_data : back_val;

  assign popped_ext = {{VALUE_W{1'b0}}, popped_val};
  assign front_ext  = {{VALUE_W{1'b0}}, front_fin};
  assign back_ext   = {{VALUE_W{1'b0}}, back_fin};
  assign occ_ext    = {{OCC_W{1'b0}}, count};

  // Result register, loaded in the response cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_RESP);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP) begin
      status      <= status_val;
      popped      <= popped_ext[VALUE_W-1:0];
      occupancy   <= occ_ext[OCC_W-1:0];
      front_value <= (count != '0) ? front_ext[VALUE_W-1:0] : '0;
      back_value  <= (count != '0) ? back_ext[VALUE_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_RESP:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("occupancy beyond capacity");

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted request without a result");

  a_no_refill_on_push: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push) |=> !refill_front && !refill_back)
    else $error("memory refill scheduled for a push");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (rst)
    (done && occupancy == '0 && DEPTH < 32) |-> (front_value == '0 && back_value == '0))
    else $error("end values not zero on an empty deque");

  a_pointer_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count == '0) |-> (back_idx == front_dec))
    else $error("end pointers out of step on an empty deque");
`endif

endmodule

>>> rtl/core/bounded_double_ended_queue_top.sv
// Top level of the bounded double-ended queue: control logic and element store.
// A request is taken when start is high and busy is low; busy then rises, and no new
// request is taken until it falls again. The result is loaded from the response state
// and shown with done high for exactly one cycle, and it cannot be held off. The
// response state serves the single read port of the element store, whose registered
// read supplies the new end element after a pop; the ends themselves are cached in
// registers. No clearing pass follows reset: the deque is empty and ready at once.
module bounded_double_ended_queue_top import bdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MODE_W-1:0]   mode,
  input  logic [VALUE_W-1:0]  value,
  output logic                busy,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  popped,
  output logic [OCC_W-1:0]    occupancy,
  output logic [VALUE_W-1:0]  front_value,
  output logic [VALUE_W-1:0]  back_value
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  wr_en, rd_en;
  logic [IW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  bdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .value       (value),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .popped      (popped),
    .occupancy   (occupancy),
    .front_value (front_value),
    .back_value  (back_value),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  bdq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> tb/bounded_double_ended_queue_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded deque: a directed table, then random requests.
module bounded_double_ended_queue_top_test;
  import bdq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_REQUESTS = 1250;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped;
    logic [OCC_W-1:0]    occupancy;
    logic [VALUE_W-1:0]  front_value;
    logic [VALUE_W-1:0]  back_value;
  } deque_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic               fixed_result;
    deque_result_t      result;
  } request_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   mode = MODE_PUSH_FRONT;
  logic [VALUE_W-1:0]  value = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  popped;
  logic [OCC_W-1:0]    occupancy;
  logic [VALUE_W-1:0]  front_value;
  logic [VALUE_W-1:0]  back_value;

  deque_result_t awaited_results [$];
  bit            mismatch_seen = 1'b0;

  // Shadow copy of the deque contents.
  logic [VALUE_W-1:0] shadow_store [DEPTH];
  int                 shadow_head = 0;
  int                 shadow_count = 0;

  // The first rows empty the deque from both ends, then sixteen pushes fill it, ending with all
  // ones at the front and zero at the back, and two pushes are refused.
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_POP_FRONT,  32'hDEAD_BEEF, 1'b1, '{STATUS_EMPTY, 32'h0, 5'd0, 32'h0, 32'h0}},
    '{MODE_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{STATUS_EMPTY, 32'h0, 5'd0, 32'h0, 32'h0}},
    '{MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_DONE, 32'h0, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{MODE_PUSH_BACK,  32'h0000_0000, 1'b1,
      '{STATUS_DONE, 32'h0, 5'd2, 32'hFFFF_FFFF, 32'h0}},
    '{MODE_POP_BACK,   32'h1234_5678, 1'b1,
      '{STATUS_DONE, 32'h0, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{MODE_POP_FRONT,  32'h0,         1'b1,
      '{STATUS_DONE, 32'hFFFF_FFFF, 5'd0, 32'h0, 32'h0}},
    '{MODE_PUSH_FRONT, 32'h8000_0000, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'h0000_0001, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'h0000_FFFF, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'hFFFF_0000, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'h1357_9BDF, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'h2468_ACE0, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'hC001_0001, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'h0000_BEEF, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, '0},
    '{MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
    '{MODE_PUSH_BACK,  32'h1234_5678, 1'b1,
      '{STATUS_FULL, 32'h0, 5'd16, 32'hFFFF_FFFF, 32'h0}},
    '{MODE_PUSH_FRONT, 32'h0,         1'b1,
      '{STATUS_FULL, 32'h0, 5'd16, 32'hFFFF_FFFF, 32'h0}},
    '{MODE_POP_FRONT,  32'hFFFF_FFFF, 1'b0, '0}
  };

  bounded_double_ended_queue_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .value       (value),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .popped      (popped),
    .occupancy   (occupancy),
    .front_value (front_value),
    .back_value  (back_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int slot_of(input int offset);
    return (shadow_head + offset) % DEPTH;
  endfunction

  // Applies one request to the shadow deque and returns the result it should give.
  function automatic deque_result_t apply_deque_request(input logic [MODE_W-1:0] req_mode,
                                                        input logic [VALUE_W-1:0] req_value);
    deque_result_t res;
    res = '0;
    res.status = STATUS_DONE;
    case (req_mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else if (req_mode == MODE_PUSH_FRONT) begin
          shadow_head = slot_of(DEPTH - 1);
          shadow_store[shadow_head] = req_value;
          shadow_count++;
        end else begin
          shadow_store[slot_of(shadow_count)] = req_value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
        end else if (req_mode == MODE_POP_FRONT) begin
          res.popped = shadow_store[shadow_head];
          shadow_head = slot_of(1);
          shadow_count--;
        end else begin
          res.popped = shadow_store[slot_of(shadow_count - 1)];
          shadow_count--;
        end
      end
    endcase
    res.occupancy = shadow_count[OCC_W-1:0];
    if (shadow_count != 0) begin
      res.front_value = shadow_store[shadow_head];
      res.back_value = shadow_store[slot_of(shadow_count - 1)];
    end
    return res;
  endfunction

  // Mostly back-to-back or short pauses, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_request(input logic [MODE_W-1:0] req_mode,
                               input logic [VALUE_W-1:0] req_value, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= req_mode;
    value <= req_value;
    do @(posedge clk); while (busy);
  endtask

  function automatic void compare_field(input string name, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: status %0d, popped %0h", status, popped);
        mismatch_seen = 1'b1;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", VALUE_W'(want.status), VALUE_W'(status));
        compare_field("popped", want.popped, popped);
        compare_field("occupancy", VALUE_W'(want.occupancy), VALUE_W'(occupancy));
        compare_field("front_value", want.front_value, front_value);
        compare_field("back_value", want.back_value, back_value);
      end
    end
  end

  initial begin
    deque_result_t      predicted;
    logic [MODE_W-1:0]  req_mode;
    logic [VALUE_W-1:0] req_value;
    int                 push_bias;
    bit                 no_gaps;
    int                 roll;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].mode, directed_rows[i].value, pick_gap());
      predicted = apply_deque_request(directed_rows[i].mode, directed_rows[i].value);
      awaited_results.push_back(directed_rows[i].fixed_result ? directed_rows[i].result
                                                              : predicted);
    end

    push_bias = 50;
    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Phases that lean towards pushes or pops drive the deque to full and to empty often.
      if (n % 40 == 0) begin
        roll = $urandom_range(0, 3);
        push_bias = (roll == 0) ? 85 : (roll == 1) ? 15 : (roll == 2) ? 60 : 40;
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      req_mode[MODE_W-1] = ($urandom_range(0, 99) >= push_bias);
      req_mode[0] = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 9);
      req_value = (roll == 0) ? '0 : (roll == 1) ? '1 : VALUE_W'($urandom);
      issue_request(req_mode, req_value, no_gaps ? 0 : pick_gap());
      awaited_results.push_back(apply_deque_request(req_mode, req_value));
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!mismatch_seen) begin
      $display("bounded_double_ended_queue_top: match");
    end else begin
      $display("bounded_double_ended_queue_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bounded_double_ended_queue_top: mismatch");
    $finish;
  end

endmodule
